[rtl/dqmb_pkg.sv]
package dqmb_pkg;

	localparam int MAX_LABEL_BYTES = 63;
	localparam int MAX_LABELS      = 64;

	localparam int LEN_W      = 6;   // label length / label store index
	localparam int TOT_W      = 7;   // label count, 0..MAX_LABELS
	localparam int MSG_W      = 13;  // message length
	localparam int CNT_W      = 6;   // emitter byte counter
	localparam int CFG_ADDR_W = 3;

	localparam int HDR_BYTES  = 12;
	localparam int TAIL_BYTES = 5;

	localparam logic [CFG_ADDR_W-1:0] ADDR_ANYQUOTE = '0;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_HYPH = 8'h2D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7A;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UZ   = 8'h5A;

	// label store write from the parser
	typedef struct packed {
		logic             en;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
	} lbl_wr_t;

	// one step's worth of output work for the emitter
	typedef struct packed {
		logic             valid;
		logic             err;
		logic             hdr;
		logic             flush;
		logic             tail;
		logic [LEN_W-1:0] flen;
		logic [15:0]      qid;
		logic [15:0]      qtype;
		logic [MSG_W-1:0] total;
	} job_t;

	// one message byte towards the packer
	typedef struct packed {
		logic             valid;
		logic             err;
		logic             step_last;
		logic             fin;
		logic [MSG_W-1:0] total;
		logic [7:0]       data;
	} msg_byte_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	// id, flags RD, QDCOUNT 1, AN/NS/ARCOUNT 0
	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid);
		logic [7:0] b;
		b = 8'h00;
		unique case (idx)
			4'd0:    b = qid[15:8];
			4'd1:    b = qid[7:0];
			4'd2:    b = 8'h01;
			4'd5:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// root byte, QTYPE, QCLASS 1
	function automatic logic [7:0] tail_byte(input logic [2:0] idx, input logic [15:0] qtype);
		logic [7:0] b;
		b = 8'h00;
		unique case (idx)
			3'd1:    b = qtype[15:8];
			3'd2:    b = qtype[7:0];
			3'd4:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/dns_query_message_builder.sv]
// DNS query message builder.
// Input stream: one beat per character of a dotted name; s_tlast marks the
// final character. query_id and query_type are sampled on a name's first beat.
// Output stream: the query message, up to two bytes per beat, header first,
// then length-prefixed labels, root byte, QTYPE and QCLASS 1. m_tlast flags
// the final beat (message_length valid there). A bad name gives one beat with
// status set and byte_count 0, and the remaining characters up to and
// including the one with s_tlast are swallowed without output.
// Flow: a beat that makes no message bytes is taken without holding the
// input. Otherwise the emitter holds s_tready low while it sends the step's
// message bytes: 12 for the header, 1 + length per label, 5 for the tail,
// or an error beat. Label bytes come from the label store, one read per
// cycle unless the output stalls, on its single read port. The first result
// beat pairs two message bytes in the packer; an error beat goes out alone.
// Reset clears all control state; the label store needs no clearing as only
// entries of the current label are read. When m_tready is low while a beat is
// pending, the emitter stalls in place and resumes with no beat lost.
// anyquote_mode (APB address 0): 1 allows backslash escapes and any byte.
module dns_query_message_builder (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dqmb_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// name characters in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// name_char[7:0], query_id[23:8], query_type[39:24]
	input  logic [39:0]                       s_tdata,
	input  logic                              s_tlast,  // name_end
	// message out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// first_byte[7:0], second_byte[15:8], byte_count[17:16],
	// message_length[30:18]
	output logic [31:0]                       m_tdata,
	output logic [0:0]                        m_tuser,  // status
	output logic                              m_tlast   // last
);
	import dqmb_pkg::*;

	logic      anyquote_q;
	logic      accept;
	job_t      job;
	lbl_wr_t   wr;
	msg_byte_t msg_byte;
	logic      pk_ready;
	logic      idle;

	// config register, written on the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anyquote_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == ADDR_ANYQUOTE)) begin
			anyquote_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ANYQUOTE) ? {31'b0, anyquote_q} : 32'b0;

	// characters are taken only while the emitter has no step in hand
	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;

	dqmb_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.name_char     (s_tdata[7:0]),
		.name_end      (s_tlast),
		.query_id      (s_tdata[23:8]),
		.query_type    (s_tdata[39:24]),
		.anyquote_mode (anyquote_q),
		.job           (job),
		.wr            (wr)
	);

	dqmb_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.wr       (wr),
		.pk_ready (pk_ready),
		.byte_o   (msg_byte),
		.idle     (idle)
	);

	dqmb_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_i   (msg_byte),
		.pk_ready (pk_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/dqmb_parse.sv]
module dqmb_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      name_char,
	input  logic            name_end,
	input  logic [15:0]     query_id,
	input  logic [15:0]     query_type,
	input  logic            anyquote_mode,
	output dqmb_pkg::job_t    job,
	output dqmb_pkg::lbl_wr_t wr
);
	import dqmb_pkg::*;

	typedef enum logic [1:0] {ESC_NONE, ESC_START, ESC_DIG1, ESC_DIG2} esc_t;

	logic [LEN_W-1:0] ll_q;
	logic [TOT_W-1:0] lt_q;
	esc_t             ph_q;
	logic [6:0]       ev_q;
	logic             inside_q;
	logic             dropping_q;
	logic [MSG_W-1:0] be_q;
	logic [15:0]      saved_type_q;

	logic             first;
	logic [LEN_W-1:0] ll, nll, flen;
	logic [TOT_W-1:0] lt, nlt;
	esc_t             ph, nph;
	logic [6:0]       ev, nev;
	logic [9:0]       ev10, ch;
	logic [3:0]       dval;
	logic             c_dig, have, fail, flush_dot, flush_end;
	logic [6:0]       nbytes;
	logic [MSG_W-1:0] total;

	always_comb begin
		first     = !inside_q;
		ll        = first ? '0 : ll_q;
		lt        = first ? '0 : lt_q;
		ph        = first ? ESC_NONE : ph_q;
		ev        = first ? '0 : ev_q;
		c_dig     = is_digit(name_char);
		dval      = name_char[3:0];
		ev10      = ({3'b0, ev} << 3) + ({3'b0, ev} << 1);
		fail      = first && (name_char == CH_NUL);
		nll       = ll;
		nlt       = lt;
		nph       = ph;
		nev       = ev;
		have      = 1'b0;
		ch        = '0;
		flush_dot = 1'b0;
		flush_end = 1'b0;

		unique case (ph)
			ESC_NONE: begin
				if (name_char == CH_BSL) begin
					if (!anyquote_mode)
						fail = 1'b1;
					nph = ESC_START;
				end else if (name_char == CH_DOT) begin
					if ((ll == '0) || (lt >= TOT_W'(MAX_LABELS)))
						fail = 1'b1;
					flush_dot = 1'b1;
					nlt       = lt + TOT_W'(1);
					nll       = '0;
				end else begin
					have = 1'b1;
					ch   = {2'b0, name_char};
				end
			end
			ESC_START: begin
				if (c_dig) begin
					nev = {3'b0, dval};
					nph = ESC_DIG1;
				end else if (name_char == CH_NUL) begin
					fail = 1'b1;
				end else begin
					have = 1'b1;
					ch   = {2'b0, name_char};
					nph  = ESC_NONE;
				end
			end
			ESC_DIG1: begin
				if (!c_dig)
					fail = 1'b1;
				nev = 7'(ev10 + {6'b0, dval});
				nph = ESC_DIG2;
			end
			ESC_DIG2: begin
				if (!c_dig)
					fail = 1'b1;
				ch  = ev10 + {6'b0, dval};
				nph = ESC_NONE;
				nev = '0;
				if (ch[9:8] != 2'b00)
					fail = 1'b1;
				have = 1'b1;
			end
		endcase

		if (have) begin
			if (!anyquote_mode) begin
				if (is_digit(ch[7:0]) || (ch[7:0] == CH_HYPH)) begin
					if (ll == '0)
						fail = 1'b1;
				end else if (!is_letter(ch[7:0])) begin
					fail = 1'b1;
				end
			end
			if (ll >= LEN_W'(MAX_LABEL_BYTES))
				fail = 1'b1;
			nll = ll + LEN_W'(1);
		end

		if (name_end) begin
			if (nph != ESC_NONE)
				fail = 1'b1;
			if (!flush_dot) begin
				if ((nll == '0) || (nlt >= TOT_W'(MAX_LABELS)))
					fail = 1'b1;
				flush_end = 1'b1;
				nlt       = nlt + TOT_W'(1);
			end
		end

		flen   = flush_dot ? ll : nll;
		nbytes = (first ? 7'(HDR_BYTES) : 7'd0)
			+ ((flush_dot || flush_end) ? (7'd1 + {1'b0, flen}) : 7'd0)
			+ (name_end ? 7'(TAIL_BYTES) : 7'd0);
		total  = (first ? '0 : be_q) + MSG_W'(nbytes);
	end

	always_comb begin
		job.valid = accept && !dropping_q
			&& (fail || first || flush_dot || flush_end || name_end);
		job.err   = fail;
		job.hdr   = first;
		job.flush = flush_dot || flush_end;
		job.tail  = name_end;
		job.flen  = flen;
		job.qid   = query_id;
		job.qtype = first ? query_type : saved_type_q;
		job.total = total;

		wr.en   = accept && !dropping_q && have && !fail;
		wr.addr = ll;
		wr.data = ch[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ll_q         <= '0;
			lt_q         <= '0;
			ph_q         <= ESC_NONE;
			ev_q         <= '0;
			inside_q     <= 1'b0;
			dropping_q   <= 1'b0;
			be_q         <= '0;
			saved_type_q <= '0;
		end else if (accept) begin
			if (dropping_q) begin
				if (name_end)
					dropping_q <= 1'b0;
			end else if (fail) begin
				ll_q       <= '0;
				ph_q       <= ESC_NONE;
				ev_q       <= '0;
				inside_q   <= 1'b0;
				dropping_q <= !name_end;
				be_q       <= '0;
			end else begin
				ll_q     <= name_end ? '0 : nll;
				lt_q     <= nlt;
				ph_q     <= nph;
				ev_q     <= nev;
				inside_q <= !name_end;
				be_q     <= total;
				if (first)
					saved_type_q <= query_type;
			end
		end
	end

endmodule

[rtl/dqmb_emit.sv]
module dqmb_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  dqmb_pkg::job_t      job,
	input  dqmb_pkg::lbl_wr_t   wr,
	input  logic                pk_ready,
	output dqmb_pkg::msg_byte_t byte_o,
	output logic                idle
);
	import dqmb_pkg::*;

	typedef enum logic [2:0] {E_IDLE, E_HDR, E_LEN, E_DATA, E_TAIL, E_ERR} emit_state_t;

	logic [7:0] mem [MAX_LABEL_BYTES];
	logic [7:0] rdata_q;

	emit_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flush_q, tail_q;
	logic [LEN_W-1:0] flen_q;
	logic [15:0]      qid_q, qtype_q;
	logic [MSG_W-1:0] total_q;

	logic             s1_valid, s1_mem, s1_sl, s1_err, s1_fin;
	logic [7:0]       s1_data;
	logic [MSG_W-1:0] s1_total;

	logic adv, rd_en, data_end;

	assign adv      = !s1_valid || pk_ready;
	assign rd_en    = adv && (state_q == E_DATA);
	assign data_end = cnt_q[LEN_W-1:0] == (flen_q - LEN_W'(1));
	assign idle     = state_q == E_IDLE;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rdata_q <= mem[cnt_q[LEN_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= '0;
			flush_q  <= 1'b0;
			tail_q   <= 1'b0;
			flen_q   <= '0;
			qid_q    <= '0;
			qtype_q  <= '0;
			total_q  <= '0;
			s1_valid <= 1'b0;
			s1_mem   <= 1'b0;
			s1_sl    <= 1'b0;
			s1_err   <= 1'b0;
			s1_fin   <= 1'b0;
			s1_data  <= '0;
			s1_total <= '0;
		end else begin
			if (adv) begin
				s1_fin   <= tail_q;
				s1_total <= total_q;
				unique case (state_q)
					E_IDLE: begin
						s1_valid <= 1'b0;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b0;
					end
					E_HDR: begin
						s1_valid <= 1'b1;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b0;
						s1_data  <= hdr_byte(cnt_q[3:0], qid_q);
						s1_sl    <= (cnt_q == CNT_W'(HDR_BYTES - 1)) && !flush_q && !tail_q;
						if (cnt_q == CNT_W'(HDR_BYTES - 1)) begin
							cnt_q <= '0;
							if (flush_q)
								state_q <= E_LEN;
							else if (tail_q)
								state_q <= E_TAIL;
							else
								state_q <= E_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					E_LEN: begin
						s1_valid <= 1'b1;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b0;
						s1_data  <= 8'(flen_q);
						s1_sl    <= 1'b0;
						cnt_q    <= '0;
						state_q  <= E_DATA;
					end
					E_DATA: begin
						s1_valid <= 1'b1;
						s1_mem   <= 1'b1;
						s1_err   <= 1'b0;
						s1_sl    <= data_end && !tail_q;
						if (data_end) begin
							cnt_q   <= '0;
							state_q <= tail_q ? E_TAIL : E_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					E_TAIL: begin
						s1_valid <= 1'b1;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b0;
						s1_data  <= tail_byte(cnt_q[2:0], qtype_q);
						s1_sl    <= cnt_q == CNT_W'(TAIL_BYTES - 1);
						if (cnt_q == CNT_W'(TAIL_BYTES - 1)) begin
							cnt_q   <= '0;
							state_q <= E_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					E_ERR: begin
						s1_valid <= 1'b1;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b1;
						s1_sl    <= 1'b1;
						s1_data  <= '0;
						state_q  <= E_IDLE;
					end
					default: begin
						s1_valid <= 1'b0;
						s1_mem   <= 1'b0;
						s1_err   <= 1'b0;
						state_q  <= E_IDLE;
					end
				endcase
			end

			// new job only lands while idle; s1 may still hold a stalled beat
			if ((state_q == E_IDLE) && job.valid) begin
				flush_q <= job.flush;
				tail_q  <= job.tail;
				flen_q  <= job.flen;
				qid_q   <= job.qid;
				qtype_q <= job.qtype;
				total_q <= job.total;
				cnt_q   <= '0;
				if (job.err)
					state_q <= E_ERR;
				else if (job.hdr)
					state_q <= E_HDR;
				else if (job.flush)
					state_q <= E_LEN;
				else
					state_q <= E_TAIL;
			end
		end
	end

	always_comb begin
		byte_o.valid     = s1_valid;
		byte_o.err       = s1_err;
		byte_o.step_last = s1_sl;
		byte_o.fin       = s1_fin;
		byte_o.total     = s1_total;
		byte_o.data      = s1_mem ? rdata_q : s1_data;
	end

endmodule

[rtl/dqmb_pack.sv]
module dqmb_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  dqmb_pkg::msg_byte_t byte_i,
	output logic                pk_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [0:0]          m_tuser,
	output logic                m_tlast
);
	import dqmb_pkg::*;

	logic             m_valid_q, m_status_q, m_last_q, hold_v_q;
	logic [7:0]       m_first_q, m_second_q, hold_q;
	logic [1:0]       m_count_q;
	logic [MSG_W-1:0] m_len_q;
	logic             take, fin_here, load;

	assign pk_ready = !m_valid_q || m_tready;
	assign take     = byte_i.valid && pk_ready;
	assign fin_here = byte_i.fin && byte_i.step_last;
	// a beat goes out on an error, a completed pair or a step's odd byte
	assign load     = take && (byte_i.err || hold_v_q || byte_i.step_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			m_status_q <= 1'b0;
			m_last_q   <= 1'b0;
			m_first_q  <= '0;
			m_second_q <= '0;
			m_count_q  <= '0;
			m_len_q    <= '0;
			hold_v_q   <= 1'b0;
			hold_q     <= '0;
		end else begin
			if (load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			if (take) begin
				priority if (byte_i.err) begin
					m_first_q  <= '0;
					m_second_q <= '0;
					m_count_q  <= 2'd0;
					m_status_q <= 1'b1;
					m_len_q    <= '0;
					m_last_q   <= 1'b1;
					hold_v_q   <= 1'b0;
				end else if (hold_v_q) begin
					m_first_q  <= hold_q;
					m_second_q <= byte_i.data;
					m_count_q  <= 2'd2;
					m_status_q <= 1'b0;
					m_len_q    <= fin_here ? byte_i.total : '0;
					m_last_q   <= fin_here;
					hold_v_q   <= 1'b0;
				end else if (byte_i.step_last) begin
					m_first_q  <= byte_i.data;
					m_second_q <= '0;
					m_count_q  <= 2'd1;
					m_status_q <= 1'b0;
					m_len_q    <= fin_here ? byte_i.total : '0;
					m_last_q   <= fin_here;
				end else begin
					hold_q   <= byte_i.data;
					hold_v_q <= 1'b1;
				end
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_len_q, m_count_q, m_second_q, m_first_q};
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

endmodule
